FILE: rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`default_nettype none

package qrs_pkg;

   // Default widths of the coefficients and of the root fraction.
   localparam int COEF_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 24;

   // Width of one root and of the packed result word.
   localparam int ROOT_WIDTH = 64;
   localparam int RSP_DATA_W = 136;

   typedef logic [1:0] count_type;

   // Root count codes.
   localparam count_type CNT_NONE = 2'd0;
   localparam count_type CNT_ONE  = 2'd1;
   localparam count_type CNT_TWO  = 2'd2;
   localparam count_type CNT_INF  = 2'd3;

   // Pipeline control handed to every cell of a chain.
   typedef struct packed {
      logic advance;
      logic valid;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
`default_nettype none

module qrs_sqrt_cell #(
   parameter int ROOT_W = 8,
   parameter int SIDE_W = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire qrs_pkg::cell_ctl_type    ctl_in,
   input  wire logic [2*ROOT_W-1:0]      rad_in,
   input  wire logic [ROOT_W+1:0]        rem_in,
   input  wire logic [ROOT_W-1:0]        root_in,
   input  wire logic [SIDE_W-1:0]        side_in,
   output logic                          valid_ff,
   output logic [2*ROOT_W-1:0]           rad_ff,
   output logic [ROOT_W+1:0]             rem_ff,
   output logic [ROOT_W-1:0]             root_ff,
   output logic [SIDE_W-1:0]             side_ff
);

   localparam int REM_W = ROOT_W + 2;

   logic [REM_W-1:0]    rem_shift;
   logic [REM_W-1:0]    trial;
   logic                take;
   logic [REM_W-1:0]    rem_in_nx;
   logic [ROOT_W-1:0]   root_in_nx;
   logic [2*ROOT_W-1:0] rad_in_nx;

   // Bring down the next two radicand bits and try root*4+1.
   always_comb begin
      rem_shift  = {rem_in[REM_W-3:0], rad_in[2*ROOT_W-1:2*ROOT_W-2]};
      trial      = {root_in, 2'b01};
      take       = (rem_shift >= trial);
      rem_in_nx  = take ? (rem_shift - trial) : rem_shift;
      root_in_nx = {root_in[ROOT_W-2:0], take};
      rad_in_nx  = {rad_in[2*ROOT_W-3:0], 2'b00};
   end

   // Valid is reset; the data registers follow the enable only.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl_in.advance) begin
         valid_ff <= ctl_in.valid;
      end
      if (ctl_in.advance) begin
         rad_ff  <= rad_in_nx;
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         side_ff <= side_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/qrs_div_cell.sv
// One cell of the two-lane divider chain: one quotient bit per lane per cell.
`default_nettype none

module qrs_div_cell #(
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 4,
   parameter int SIDE_W = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qrs_pkg::cell_ctl_type ctl_in,
   input  wire logic [DEN_W-1:0]      den_in,
   input  wire logic [NUM_W-1:0]      num_a_in,
   input  wire logic [NUM_W-1:0]      num_b_in,
   input  wire logic [DEN_W:0]        rem_a_in,
   input  wire logic [DEN_W:0]        rem_b_in,
   input  wire logic [NUM_W-1:0]      quo_a_in,
   input  wire logic [NUM_W-1:0]      quo_b_in,
   input  wire logic [SIDE_W-1:0]     side_in,
   output logic                       valid_ff,
   output logic [DEN_W-1:0]           den_ff,
   output logic [NUM_W-1:0]           num_a_ff,
   output logic [NUM_W-1:0]           num_b_ff,
   output logic [DEN_W:0]             rem_a_ff,
   output logic [DEN_W:0]             rem_b_ff,
   output logic [NUM_W-1:0]           quo_a_ff,
   output logic [NUM_W-1:0]           quo_b_ff,
   output logic [SIDE_W-1:0]          side_ff
);

   logic [DEN_W:0] sh_a, sh_b, den_x;
   logic           ge_a, ge_b;
   logic [DEN_W:0] rem_a_nx, rem_b_nx;

   // Shift in the next numerator bit and subtract the divisor when it fits.
   always_comb begin
      den_x    = {1'b0, den_in};
      sh_a     = {rem_a_in[DEN_W-1:0], num_a_in[NUM_W-1]};
      sh_b     = {rem_b_in[DEN_W-1:0], num_b_in[NUM_W-1]};
      ge_a     = (sh_a >= den_x);
      ge_b     = (sh_b >= den_x);
      rem_a_nx = ge_a ? (sh_a - den_x) : sh_a;
      rem_b_nx = ge_b ? (sh_b - den_x) : sh_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl_in.advance) begin
         valid_ff <= ctl_in.valid;
      end
      if (ctl_in.advance) begin
         den_ff   <= den_in;
         num_a_ff <= {num_a_in[NUM_W-2:0], 1'b0};
         num_b_ff <= {num_b_in[NUM_W-2:0], 1'b0};
         rem_a_ff <= rem_a_nx;
         rem_b_ff <= rem_b_nx;
         quo_a_ff <= {quo_a_in[NUM_W-2:0], ge_a};
         quo_b_ff <= {quo_b_in[NUM_W-2:0], ge_b};
         side_ff  <= side_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/quadratic_root_solver_core.sv
// Top level of the quadratic root solver: front stages, cell chains and result stages.
//
// Usage: one word on req_ carries the coefficients a, b and c of a*x^2+b*x+c=0.
// One word on rsp_ returns the root count and the roots in ascending order as
// signed fixed point with FRAC_BITS fraction bits; unused roots are zero and a
// single root fills both fields.
// The pipeline runs through three front stages, one square root cell per root
// bit, one stage that forms the numerators, one divider cell per quotient bit,
// one saturation stage and the output register.
// Throughput is one word per cycle while the receiver does not stall; every stage is a plain register stage.
// Reset clears all valid bits; the chains then hold no words.
// When the receiver stalls with a word in the output register, the whole
// pipeline holds and req_tready drops until rsp_tready returns.
`default_nettype none

module quadratic_root_solver_core #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // coef_quad, coef_lin, coef_const from the lowest bit up
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // root_count, root_small, root_large from the lowest bit up
   output logic [qrs_pkg::RSP_DATA_W-1:0]             rsp_tdata
);

   localparam int W    = COEF_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W;
   localparam int DW   = 2 * W + 1;
   localparam int SW   = W + F + 1;
   localparam int RW   = 2 * SW;
   localparam int NW   = W + F + 2;
   localparam int DNW  = W + 1;
   localparam int RTW  = qrs_pkg::ROOT_WIDTH;
   localparam int QXW  = (NW > RTW) ? NW : RTW;
   localparam int SS_W = 3 * W + 8;
   localparam int SD_W = 5;
   localparam int PAD_W = qrs_pkg::RSP_DATA_W - 2 - 2 * RTW;

   localparam logic [QXW-1:0] LIM_POS = QXW'({1'b0, {(RTW-1){1'b1}}});
   localparam logic [QXW-1:0] LIM_NEG = QXW'({1'b1, {(RTW-1){1'b0}}});

   logic adv;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------------------------------------------------------
   // Stage 1: split the coefficients into magnitude and sign.
   // ---------------------------------------------------------------
   logic [W-1:0] qa, qb, qc;
   logic         v1_ff;
   logic [W-1:0] am1_ff, bm1_ff, cm1_ff, am1_in, bm1_in, cm1_in;
   logic         an1_ff, bn1_ff, cn1_ff;

   always_comb begin
      qa     = req_tdata[W-1:0];
      qb     = req_tdata[2*W-1:W];
      qc     = req_tdata[3*W-1:2*W];
      am1_in = qa[W-1] ? (W'(0) - qa) : qa;
      bm1_in = qb[W-1] ? (W'(0) - qb) : qb;
      cm1_in = qc[W-1] ? (W'(0) - qc) : qc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
      if (adv) begin
         am1_ff <= am1_in;
         bm1_ff <= bm1_in;
         cm1_ff <= cm1_in;
         an1_ff <= qa[W-1];
         bn1_ff <= qb[W-1];
         cn1_ff <= qc[W-1];
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: products b*b and a*c, plus zero flags.
   // ---------------------------------------------------------------
   logic          v2_ff;
   logic [PW-1:0] bb2_ff, ac2_ff;
   logic [W-1:0]  am2_ff, bm2_ff, cm2_ff;
   logic          an2_ff, bn2_ff, cn2_ff, az2_ff, bz2_ff, cz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         bb2_ff <= PW'(bm1_ff) * PW'(bm1_ff);
         ac2_ff <= PW'(am1_ff) * PW'(cm1_ff);
         am2_ff <= am1_ff;
         bm2_ff <= bm1_ff;
         cm2_ff <= cm1_ff;
         an2_ff <= an1_ff;
         bn2_ff <= bn1_ff;
         cn2_ff <= cn1_ff;
         az2_ff <= (am1_ff == '0);
         bz2_ff <= (bm1_ff == '0);
         cz2_ff <= (cm1_ff == '0);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: discriminant and first classification.
   // ---------------------------------------------------------------
   logic               v3_ff;
   logic [DW-1:0]      bbx, ac4, dsum, d3_in, d3_ff;
   logic [DW:0]        ddif;
   qrs_pkg::count_type cnt3_in, cnt3_ff;
   logic               lin3_in, lin3_ff;
   logic [W-1:0]       am3_ff, bm3_ff, cm3_ff;
   logic               an3_ff, bn3_ff, cn3_ff, bz3_ff, cz3_ff;

   always_comb begin
      bbx     = DW'(bb2_ff);
      ac4     = {ac2_ff[PW-2:0], 2'b00};
      dsum    = bbx + ac4;
      ddif    = {1'b0, bbx} - {1'b0, ac4};
      d3_in   = '0;
      lin3_in = 1'b0;
      cnt3_in = qrs_pkg::CNT_NONE;
      if (az2_ff) begin
         // Linear or degenerate equation.
         if (bz2_ff) begin
            cnt3_in = cz2_ff ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
         end else begin
            cnt3_in = qrs_pkg::CNT_ONE;
            lin3_in = 1'b1;
         end
      end else if (cz2_ff || (an2_ff != cn2_ff)) begin
         d3_in   = dsum;
         cnt3_in = qrs_pkg::CNT_TWO;
      end else if (!ddif[DW]) begin
         d3_in   = ddif[DW-1:0];
         cnt3_in = qrs_pkg::CNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         d3_ff   <= d3_in;
         cnt3_ff <= cnt3_in;
         lin3_ff <= lin3_in;
         am3_ff  <= am2_ff;
         bm3_ff  <= bm2_ff;
         cm3_ff  <= cm2_ff;
         an3_ff  <= an2_ff;
         bn3_ff  <= bn2_ff;
         cn3_ff  <= cn2_ff;
         bz3_ff  <= bz2_ff;
         cz3_ff  <= cz2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Square root chain over D * 2^(2F), one root bit per cell.
   // ---------------------------------------------------------------
   logic [RW-1:0]   sq_rad  [0:SW];
   logic [SW+1:0]   sq_rem  [0:SW];
   logic [SW-1:0]   sq_root [0:SW];
   logic [SS_W-1:0] sq_side [0:SW];
   logic            sq_val  [0:SW];

   assign sq_rad[0]  = {1'b0, d3_ff, {(2*F){1'b0}}};
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_val[0]  = v3_ff;
   assign sq_side[0] = {lin3_ff, cnt3_ff, am3_ff, an3_ff, bm3_ff, bn3_ff, bz3_ff,
                        cm3_ff, cn3_ff, cz3_ff};

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_pkg::cell_ctl_type ctl;
      assign ctl = '{advance: adv, valid: sq_val[i]};
      qrs_sqrt_cell #(
         .ROOT_W (SW),
         .SIDE_W (SS_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl),
         .rad_in   (sq_rad[i]),
         .rem_in   (sq_rem[i]),
         .root_in  (sq_root[i]),
         .side_in  (sq_side[i]),
         .valid_ff (sq_val[i+1]),
         .rad_ff   (sq_rad[i+1]),
         .rem_ff   (sq_rem[i+1]),
         .root_ff  (sq_root[i+1]),
         .side_ff  (sq_side[i+1])
      );
   end

   // ---------------------------------------------------------------
   // Numerator stage: -b*2^F -/+ s for the two roots, or -c*2^F.
   // ---------------------------------------------------------------
   logic               s_lin, s_an, s_bn, s_bz, s_cn, s_cz;
   qrs_pkg::count_type s_cnt, cnt4_in;
   logic [W-1:0]       s_am, s_bm, s_cm;
   logic [NW-1:0]      nb, sx, nsum, s_minus_nb;
   logic [NW:0]        nb_minus_s;
   logic               nbneg, nb_ge;
   logic [NW-1:0]      na4_in, nb4_in;
   logic               sa4_in, sb4_in;
   logic [DNW-1:0]     den4_in;

   logic               v4_ff;
   logic [NW-1:0]      na4_ff, nb4_ff;
   logic [DNW-1:0]     den4_ff;
   logic [SD_W-1:0]    sd4_ff;

   always_comb begin
      {s_lin, s_cnt, s_am, s_an, s_bm, s_bn, s_bz, s_cm, s_cn, s_cz} = sq_side[SW];
      nb         = NW'({s_bm, {F{1'b0}}});
      sx         = NW'(sq_root[SW]);
      nbneg      = !s_bz && !s_bn;
      nsum       = nb + sx;
      nb_minus_s = {1'b0, nb} - {1'b0, sx};
      s_minus_nb = sx - nb;
      nb_ge      = !nb_minus_s[NW];
      cnt4_in    = s_cnt;
      if (s_lin) begin
         na4_in  = NW'({s_cm, {F{1'b0}}});
         nb4_in  = na4_in;
         sa4_in  = (!s_cz && !s_cn) ^ s_bn;
         sb4_in  = sa4_in;
         den4_in = {1'b0, s_bm};
      end else begin
         // Signed magnitude sums of (-b) with -s and with +s.
         na4_in  = nbneg ? nsum : (nb_ge ? nb_minus_s[NW-1:0] : s_minus_nb);
         nb4_in  = nbneg ? (nb_ge ? nb_minus_s[NW-1:0] : s_minus_nb) : nsum;
         sa4_in  = (nbneg || !nb_ge) ^ s_an;
         sb4_in  = (nbneg && nb_ge) ^ s_an;
         den4_in = {s_am, 1'b0};
         if ((s_cnt == qrs_pkg::CNT_TWO) && (sq_root[SW] == '0)) begin
            cnt4_in = qrs_pkg::CNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= sq_val[SW];
      end
      if (adv) begin
         na4_ff  <= na4_in;
         nb4_ff  <= nb4_in;
         den4_ff <= den4_in;
         sd4_ff  <= {s_lin, cnt4_in, sa4_in, sb4_in};
      end
   end

   // ---------------------------------------------------------------
   // Divider chain, two lanes sharing the divisor.
   // ---------------------------------------------------------------
   logic [DNW-1:0]  dv_den   [0:NW];
   logic [NW-1:0]   dv_num_a [0:NW];
   logic [NW-1:0]   dv_num_b [0:NW];
   logic [DNW:0]    dv_rem_a [0:NW];
   logic [DNW:0]    dv_rem_b [0:NW];
   logic [NW-1:0]   dv_quo_a [0:NW];
   logic [NW-1:0]   dv_quo_b [0:NW];
   logic [SD_W-1:0] dv_side  [0:NW];
   logic            dv_val   [0:NW];

   assign dv_den[0]   = den4_ff;
   assign dv_num_a[0] = na4_ff;
   assign dv_num_b[0] = nb4_ff;
   assign dv_rem_a[0] = '0;
   assign dv_rem_b[0] = '0;
   assign dv_quo_a[0] = '0;
   assign dv_quo_b[0] = '0;
   assign dv_side[0]  = sd4_ff;
   assign dv_val[0]   = v4_ff;

   for (genvar j = 0; j < NW; j++) begin : g_div
      qrs_pkg::cell_ctl_type ctl;
      assign ctl = '{advance: adv, valid: dv_val[j]};
      qrs_div_cell #(
         .NUM_W  (NW),
         .DEN_W  (DNW),
         .SIDE_W (SD_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl),
         .den_in   (dv_den[j]),
         .num_a_in (dv_num_a[j]),
         .num_b_in (dv_num_b[j]),
         .rem_a_in (dv_rem_a[j]),
         .rem_b_in (dv_rem_b[j]),
         .quo_a_in (dv_quo_a[j]),
         .quo_b_in (dv_quo_b[j]),
         .side_in  (dv_side[j]),
         .valid_ff (dv_val[j+1]),
         .den_ff   (dv_den[j+1]),
         .num_a_ff (dv_num_a[j+1]),
         .num_b_ff (dv_num_b[j+1]),
         .rem_a_ff (dv_rem_a[j+1]),
         .rem_b_ff (dv_rem_b[j+1]),
         .quo_a_ff (dv_quo_a[j+1]),
         .quo_b_ff (dv_quo_b[j+1]),
         .side_ff  (dv_side[j+1])
      );
   end

   // ---------------------------------------------------------------
   // Saturation stage: apply the sign and clamp to the root width.
   // ---------------------------------------------------------------
   logic               f_lin, f_sa, f_sb;
   qrs_pkg::count_type f_cnt;
   logic [QXW-1:0]     qxa, qxb, mga, mgb;
   logic [RTW-1:0]     r1_in, r2_in;

   logic               v5_ff;
   logic [RTW-1:0]     r1_ff, r2_ff;
   logic               lin5_ff;
   qrs_pkg::count_type cnt5_ff;

   always_comb begin
      {f_lin, f_cnt, f_sa, f_sb} = dv_side[NW];
      qxa   = QXW'(dv_quo_a[NW]);
      qxb   = QXW'(dv_quo_b[NW]);
      mga   = f_sa ? ((qxa > LIM_NEG) ? LIM_NEG : qxa) : ((qxa > LIM_POS) ? LIM_POS : qxa);
      mgb   = f_sb ? ((qxb > LIM_NEG) ? LIM_NEG : qxb) : ((qxb > LIM_POS) ? LIM_POS : qxb);
      r1_in = f_sa ? (RTW'(0) - mga[RTW-1:0]) : mga[RTW-1:0];
      r2_in = f_sb ? (RTW'(0) - mgb[RTW-1:0]) : mgb[RTW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= dv_val[NW];
      end
      if (adv) begin
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         lin5_ff <= f_lin;
         cnt5_ff <= f_cnt;
      end
   end

   // ---------------------------------------------------------------
   // Output register: order the roots and blank the unused ones.
   // ---------------------------------------------------------------
   logic [RTW-1:0] lo_in, hi_in;
   logic           rsp_tvalid_ff;
   logic [qrs_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   always_comb begin
      if ((cnt5_ff == qrs_pkg::CNT_NONE) || (cnt5_ff == qrs_pkg::CNT_INF)) begin
         lo_in = '0;
         hi_in = '0;
      end else if (lin5_ff) begin
         lo_in = r1_ff;
         hi_in = r1_ff;
      end else if ($signed(r1_ff) > $signed(r2_ff)) begin
         lo_in = r2_ff;
         hi_in = r1_ff;
      end else begin
         lo_in = r1_ff;
         hi_in = r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= v5_ff;
      end
      if (adv) begin
         rsp_tdata_ff <= {{PAD_W{1'b0}}, hi_in, lo_in, cnt5_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------
   // Checks on the result logic.
   // ---------------------------------------------------------------
   logic [1:0]     chk_cnt;
   logic [RTW-1:0] chk_lo, chk_hi;

   assign chk_cnt = rsp_tdata_ff[1:0];
   assign chk_lo  = rsp_tdata_ff[RTW+1:2];
   assign chk_hi  = rsp_tdata_ff[2*RTW+1:RTW+2];

   // No roots or infinitely many roots report zero in both fields.
   a_blank_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && ((chk_cnt == qrs_pkg::CNT_NONE) || (chk_cnt == qrs_pkg::CNT_INF))
      |-> (chk_lo == '0) && (chk_hi == '0))
      else $error("unused roots are not zero");

   // Roots leave in ascending order.
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> ($signed(chk_lo) <= $signed(chk_hi)))
      else $error("roots are not in ascending order");

   // A single root fills both fields.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (chk_cnt == qrs_pkg::CNT_ONE) |-> (chk_lo == chk_hi))
      else $error("single root differs between fields");

   // The input side only stalls behind a stalled output word.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid_ff && !rsp_tready))
      else $error("input stalled without an output stall");

   // A held output word keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> $stable(rsp_tdata_ff) && rsp_tvalid_ff)
      else $error("stalled output word changed");

endmodule

`default_nettype wire
